/* rtl/gvn_pkg.sv */
// Package for the grid vertex normal generator.
// Holds payload structs, command/status structs and fixed constants.
// No dependencies.
package gvn_pkg;

  localparam int PosW = 24;
  localparam int NrmW = 16;
  localparam logic [NrmW-1:0] OneQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
  } vertex_t;

  typedef struct packed {
    logic [5:0]              column;
    logic [11:0]             row;
    logic [1:0]              corner;
    logic signed [NrmW-1:0]  normal_x;
    logic signed [NrmW-1:0]  normal_y;
    logic signed [NrmW-1:0]  normal_z;
    logic                    last;
  } normal_t;

  localparam logic [6:0] RegWidthRst  = 7'd35;
  localparam logic [12:0] RegLengthRst = 13'd50;
  localparam logic [0:0] AddrWidth = 1'b0;
  localparam logic [0:0] AddrLength = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;      // read neighbors, form differences
    logic       cross_go;  // start cross product for corner
    logic [1:0] corner;
    logic       norm_go;   // start normalizer
    logic       store;     // write incoming vertex to row store
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
  } dp_sts_t;

endpackage

/* rtl/gvn_norm.sv */
// Iterative normalizer: shift to 16 bits, sum of squares, three divisions
// and three square roots, one bit per cycle.
module gvn_norm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [50:0]    cx,
  input  logic signed [50:0]    cy,
  input  logic signed [50:0]    cz,
  output logic                  done,
  output logic [47:0]           nrm
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SHIFT = 3'd1, S_SQ = 3'd2,
    S_DIV = 3'd3, S_SQRT = 3'd4, S_OUT = 3'd5;

  logic [2:0]  state;
  logic [50:0] m [3];
  logic [2:0]  neg;
  logic [15:0] m16 [3];
  logic [1:0]  sel;
  logic [1:0]  comp;
  logic [33:0] sum;
  logic [5:0]  cnt;
  logic [62:0] rem;
  logic [31:0] quo;
  logic [31:0] sq_v;
  logic [33:0] sq_r;
  logic [33:0] sq_res;
  logic [15:0] res [3];
  logic [31:0] msq;
  logic [62:0] rem_sh;
  logic [33:0] trial;

  assign msq    = m16[comp] * m16[comp];
  assign rem_sh = {rem[61:0], quo[31]};
  assign trial  = {sq_r[31:0], sq_v[31:30]} - {sq_res[31:0], 2'b01};

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_OUT) && (comp == 2'd2);
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            m[0] <= cx[50] ? -cx : cx;
            m[1] <= cy[50] ? -cy : cy;
            m[2] <= cz[50] ? -cz : cz;
            neg <= {cz[50], cy[50], cx[50]};
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ((m[0][50:16] | m[1][50:16] | m[2][50:16]) != '0) begin
            m[0] <= m[0] >> 1;
            m[1] <= m[1] >> 1;
            m[2] <= m[2] >> 1;
          end else begin
            m16[0] <= m[0][15:0];
            m16[1] <= m[1][15:0];
            m16[2] <= m[2][15:0];
            sum <= '0;
            sel <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sum <= sum + 34'(m16[sel]) * 34'(m16[sel]);
          if (sel == 2'd2) begin
            comp <= 2'd0;
            state <= S_DIV;
            cnt <= '0;
            rem <= '0;
          end
          sel <= sel + 2'd1;
          if (sel == 2'd0) quo <= '0;
        end
        S_DIV: begin
          // restoring division of msq*2^30 by sum, 62 quotient bits, keep low 32
          if (cnt == 6'd0) begin
            quo <= msq;
            rem <= '0;
            sq_v <= '0;
            cnt <= 6'd1;
          end else begin
            if (sum == '0) begin
              sq_v <= '0;
              cnt <= '0;
              sq_r <= '0;
              sq_res <= '0;
              state <= S_SQRT;
            end else begin
              if (rem_sh >= {29'b0, sum}) begin
                rem <= rem_sh - {29'b0, sum};
                sq_v <= {sq_v[30:0], 1'b1};
              end else begin
                rem <= rem_sh;
                sq_v <= {sq_v[30:0], 1'b0};
              end
              quo <= {quo[30:0], 1'b0};
              if (cnt == 6'd62) begin
                cnt <= '0;
                sq_r <= '0;
                sq_res <= '0;
                state <= S_SQRT;
              end else begin
                cnt <= cnt + 6'd1;
              end
            end
          end
        end
        S_SQRT: begin
          // quotient < 2^31 always (m^2 <= sum); digit-by-digit square root
          if (!trial[33]) begin
            sq_r <= trial;
            sq_res <= {sq_res[32:0], 1'b1};
          end else begin
            sq_r <= {sq_r[31:0], sq_v[31:30]};
            sq_res <= {sq_res[32:0], 1'b0};
          end
          sq_v <= {sq_v[29:0], 2'b00};
          if (cnt == 6'd15) begin
            state <= S_OUT;
          end
          cnt <= cnt + 6'd1;
        end
        S_OUT: begin
          res[comp] <= 16'((sq_res[16:0] + 17'd1) >> 1);
          if (comp == 2'd2) begin
            state <= S_IDLE;
          end else begin
            comp <= comp + 2'd1;
            cnt <= '0;
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    nrm[47:32] = neg[0] ? -res[0] : res[0];
    nrm[31:16] = neg[1] ? -res[1] : res[1];
    nrm[15:0]  = neg[2] ? -res[2] : res[2];
  end
endmodule

/* rtl/gvn_datapath.sv */
// Datapath: row store memory, neighbor differences, cross product, normalizer.
// Uses gvn_pkg and gvn_norm.
module gvn_datapath #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gvn_pkg::dp_cmd_t                      cmd,
  input  gvn_pkg::vertex_t                      vtx,
  input  logic [$clog2(MAX_COLUMNS)-1:0]        col,
  input  logic                                  par,
  output gvn_pkg::dp_sts_t                      sts,
  output logic [47:0]                           nrm
);
  localparam int CW = $clog2(MAX_COLUMNS);

  logic [71:0] mem [2**(CW+1)];
  logic [71:0] rd;
  logic [1:0]  rsel;
  logic [2:0]  rstep;
  logic signed [24:0] ctr [3], d [4][3];
  logic signed [24:0] a [3], b [3];
  logic signed [49:0] pa, pb;
  logic signed [50:0] cr [3];
  logic [1:0]  cstep;
  logic        cbusy, ngo;
  logic [CW:0] raddr;
  logic signed [23:0] p [3];

  // read sequence: center, left, right, down (one per cycle)
  always_comb begin
    case (rsel)
      2'd0: raddr = {~par, col};
      2'd1: raddr = {~par, col - CW'(1)};
      2'd2: raddr = {~par, col + CW'(1)};
      default: raddr = {par, col};
    endcase
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (cmd.store) mem[{par, col}] <= {vtx.pos_x, vtx.pos_y, vtx.pos_z};
  end

  assign p[0] = rd[71:48];
  assign p[1] = rd[47:24];
  assign p[2] = rd[23:0];

  // d[0]=up, d[1]=left, d[2]=right, d[3]=down
  always_ff @(posedge clk) begin
    if (rst) begin
      rstep <= '0;
      rsel <= '0;
    end else if (cmd.load) begin
      rstep <= 3'd1;
      rsel <= 2'd1;
      d[0][0] <= 25'(vtx.pos_x);
      d[0][1] <= 25'(vtx.pos_y);
      d[0][2] <= 25'(vtx.pos_z);
    end else if (rstep != 0) begin
      rstep <= (rstep == 3'd4) ? 3'd0 : rstep + 3'd1;
      rsel <= rsel + 2'd1;
      for (int j = 0; j < 3; j++) begin
        case (rstep)
          3'd1: begin
            ctr[j] <= 25'(p[j]);
            d[0][j] <= d[0][j] - 25'(p[j]);
          end
          3'd2: d[1][j] <= 25'(p[j]) - ctr[j];
          3'd3: d[2][j] <= 25'(p[j]) - ctr[j];
          default: d[3][j] <= 25'(p[j]) - ctr[j];
        endcase
      end
    end else begin
      rsel <= '0;
    end
  end

  always_comb begin
    case (cmd.corner)
      2'd0: begin a = d[0]; b = d[1]; end
      2'd1: begin a = d[2]; b = d[0]; end
      2'd2: begin a = d[1]; b = d[3]; end
      default: begin a = d[3]; b = d[2]; end
    endcase
  end

  // two products registered, then subtracted while the next component's products are formed
  always_ff @(posedge clk) begin
    ngo <= !rst && !cmd.cross_go && cbusy && (cstep == 2'd3);
    if (rst) begin
      cbusy <= 1'b0;
      cstep <= '0;
    end else if (cmd.cross_go) begin
      cbusy <= 1'b1;
      cstep <= '0;
    end else if (cbusy) begin
      case (cstep)
        2'd0: begin pa <= a[1] * b[2]; pb <= a[2] * b[1]; end
        2'd1: begin cr[0] <= 51'(pa) - 51'(pb); pa <= a[2] * b[0]; pb <= a[0] * b[2]; end
        2'd2: begin cr[1] <= 51'(pa) - 51'(pb); pa <= a[0] * b[1]; pb <= a[1] * b[0]; end
        default: begin
          cr[2] <= 51'(pa) - 51'(pb);
          cbusy <= 1'b0;
        end
      endcase
      cstep <= cstep + 2'd1;
    end
  end

  gvn_norm u_norm (
    .clk(clk), .rst(rst), .start(ngo),
    .cx(cr[0]), .cy(cr[1]), .cz(cr[2]),
    .done(sts.norm_done), .nrm(nrm)
  );
endmodule

/* rtl/gvn_ctrl.sv */
// Controller: grid counters, result sequencing and output register.
// Uses gvn_pkg; drives gvn_datapath by command struct.
module gvn_ctrl #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [6:0]                       grid_width,
  input  logic [12:0]                      grid_length,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gvn_pkg::vertex_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output gvn_pkg::normal_t                 out_data,
  output gvn_pkg::dp_cmd_t                 cmd,
  output gvn_pkg::vertex_t                 vtx,
  output logic [$clog2(MAX_COLUMNS)-1:0]   col,
  output logic                             par,
  input  gvn_pkg::dp_sts_t                 sts,
  input  logic [47:0]                      nrm
);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_WAITLD = 4'd2,
    S_CROSS = 4'd3, S_NORM = 4'd4, S_FLAT = 4'd5, S_OUT = 4'd6,
    S_OWN = 4'd7, S_STORE = 4'd8, S_ADV = 4'd9;

  logic [3:0]  state;
  logic [CW:0] cc;
  logic [RW:0] rc;
  logic [CW:0] w;
  logic [RW:0] len;
  logic [CW-1:0] c;
  logic [1:0]  corner;
  logic [2:0]  wait_cnt;
  logic        own, have_own, flat;
  logic [47:0] nrm_hold;
  gvn_pkg::dp_cmd_t cmd_next;

  always_comb begin
    if (grid_width < 7'd2) w = (CW+1)'(2);
    else if (32'(grid_width) > MAX_COLUMNS) w = (CW+1)'(MAX_COLUMNS);
    else w = (CW+1)'(grid_width);
    if (grid_length < 13'd2) len = (RW+1)'(2);
    else if (32'(grid_length) > MAX_ROWS) len = (RW+1)'(MAX_ROWS);
    else len = (RW+1)'(grid_length);
  end

  assign c = (cc >= w) ? CW'(w - 1'b1) : cc[CW-1:0];
  assign col = c;
  assign par = rc[0];
  assign in_ready = (state == S_IDLE);
  assign have_own = (rc == len - 1'b1);

  always_comb begin
    cmd_next = '0;
    case (state)
      S_LOAD: cmd_next.load = !flat;
      S_CROSS: begin
        cmd_next.cross_go = 1'b1;
        cmd_next.corner = corner;
      end
      S_NORM: cmd_next.corner = corner;
      S_STORE: cmd_next.store = 1'b1;
      default: cmd_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) cmd <= '0;
    else cmd <= cmd_next;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) begin
        state <= S_IDLE;
        out_valid <= 1'b0;
      end
      cc <= '0;
      rc <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            vtx <= in_data;
            corner <= '0;
            own <= 1'b0;
            if (rc == '0) begin
              state <= have_own ? S_OWN : S_STORE;
            end else begin
              flat <= (rc == (RW+1)'(1)) || (c == '0) || ({1'b0, c} == w - 1'b1);
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (flat) begin
            state <= S_FLAT;
          end else begin
            wait_cnt <= '0;
            state <= S_WAITLD;
          end
        end
        S_WAITLD: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd5) state <= S_CROSS;
        end
        S_CROSS: begin
          state <= S_NORM;
        end
        S_NORM: begin
          if (sts.norm_done) begin
            nrm_hold <= nrm;
            state <= S_OUT;
          end
        end
        S_FLAT: begin
          nrm_hold <= {16'h0000, gvn_pkg::OneQ14, 16'h0000};
          state <= S_OUT;
        end
        S_OWN: begin
          own <= 1'b1;
          corner <= '0;
          flat <= 1'b1;
          state <= S_FLAT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.column <= 6'(c);
            out_data.row <= own ? 12'(rc) : 12'(rc - 1'b1);
            out_data.corner <= corner;
            out_data.normal_x <= nrm_hold[47:32];
            out_data.normal_y <= nrm_hold[31:16];
            out_data.normal_z <= nrm_hold[15:0];
            out_data.last <= (corner == 2'd3) && (own || !have_own);
            corner <= corner + 2'd1;
            if (corner != 2'd3) state <= flat ? S_FLAT : S_CROSS;
            else if (!own && have_own) state <= S_OWN;
            else state <= S_STORE;
          end
        end
        S_STORE: begin
          state <= S_ADV;
        end
        S_ADV: begin
          state <= S_IDLE;
          if ({1'b0, c} + 1'b1 >= w) begin
            cc <= '0;
            rc <= (rc + 1'b1 >= len) ? '0 : rc + 1'b1;
          end else begin
            cc <= {1'b0, c} + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end
endmodule

/* rtl/grid_vertex_normal_generator.sv */
// Grid vertex normal generator, top level: APB registers, controller, datapath.
// Each interior vertex yields four normals, each through a bit-serial divider and square
// root; border vertices get flat normals, first-row vertices are only stored, and
// last-row vertices add four flat normals of their own. Output stalls add to the time.
// Throughput: one vertex at a time, set by the shared iterative normalizer.
// Reset: synchronous rst clears counters, state and configuration registers; row store is not cleared.
module grid_vertex_normal_generator #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  gvn_pkg::vertex_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gvn_pkg::normal_t   out_data
);
  localparam int CW = $clog2(MAX_COLUMNS);

  logic [6:0]  grid_width;
  logic [12:0] grid_length;
  logic        cfg_we;
  gvn_pkg::dp_cmd_t cmd;
  gvn_pkg::dp_sts_t sts;
  gvn_pkg::vertex_t vtx;
  logic [CW-1:0] col;
  logic par;
  logic [47:0] nrm;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
    (paddr[2] == gvn_pkg::AddrWidth || paddr[2] == gvn_pkg::AddrLength);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= gvn_pkg::RegWidthRst;
      grid_length <= gvn_pkg::RegLengthRst;
    end else if (cfg_we) begin
      if (paddr[2] == gvn_pkg::AddrWidth) grid_width <= pwdata[6:0];
      else grid_length <= pwdata[12:0];
    end
  end

  assign prdata = (paddr[2] == gvn_pkg::AddrWidth) ? {25'b0, grid_width} : {19'b0, grid_length};

  gvn_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .grid_width(grid_width),
    .grid_length(grid_length), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cmd(cmd), .vtx(vtx), .col(col), .par(par),
    .sts(sts), .nrm(nrm)
  );

  gvn_datapath #(.MAX_COLUMNS(MAX_COLUMNS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .vtx(vtx), .col(col), .par(par),
    .sts(sts), .nrm(nrm)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while waiting");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.cross_go, cmd.store}) <= 1) else $error("command overlap");
endmodule

/* sim/tb.sv */
// Testbench for grid_vertex_normal_generator: streams grid vertices, predicts
// every corner normal in fixed point and checks the output stream in order.
// Depends on rtl/gvn_pkg.sv and rtl/grid_vertex_normal_generator.sv.
`timescale 1ns / 100ps

module tb;

  localparam int MaxCols = 64;
  localparam int MaxRows = 4096;
  localparam logic [2:0] RegAddrWidth = 3'd0;
  localparam logic [2:0] RegAddrLength = 3'd4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  gvn_pkg::vertex_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gvn_pkg::normal_t out_data;

  gvn_pkg::vertex_t vertex_q[$];
  gvn_pkg::normal_t normal_q[$];
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int errors = 0;
  int n_vertices = 0;
  int n_normals = 0;

  logic [23:0] store_x[2*MaxCols];
  logic [23:0] store_y[2*MaxCols];
  logic [23:0] store_z[2*MaxCols];
  int col_cnt = 0, row_cnt = 0;
  int cfg_width = 35, cfg_length = 50;

  grid_vertex_normal_generator u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  always #1 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic unit_normal(input longint c[3], output logic [15:0] o[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, q, k;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= 65536) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= s;
      sum += m[i] * m[i];
    end
    for (int i = 0; i < 3; i++) begin
      k = 0;
      if (sum != 0) begin
        q = ((m[i] * m[i]) << 30) / sum;
        k = (int_sqrt(q) + 1) / 2;
      end
      o[i] = c[i] < 0 ? 16'(-k) : 16'(k);
    end
  endtask

  function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic void push_normal(int c, int r, int k, logic [15:0] n[3]);
    gvn_pkg::normal_t e;
    e.column = 6'(c);
    e.row = 12'(r);
    e.corner = 2'(k);
    e.normal_x = n[0];
    e.normal_y = n[1];
    e.normal_z = n[2];
    e.last = 1'b0;
    normal_q.push_back(e);
  endfunction

  task automatic predict_normals(gvn_pkg::vertex_t v);
    int w, len, c, r, cur, prv, n0;
    longint p[3], ctr[3], lp[3], rp[3], dp[3], up[3], dn[3], lf[3], rt[3], x[3];
    logic [15:0] flat[3], nv[3];
    flat[0] = '0;
    flat[1] = gvn_pkg::OneQ14;
    flat[2] = '0;
    w = cfg_width < 2 ? 2 : (cfg_width > MaxCols ? MaxCols : cfg_width);
    len = cfg_length < 2 ? 2 : (cfg_length > MaxRows ? MaxRows : cfg_length);
    c = col_cnt >= w ? w - 1 : col_cnt;
    r = row_cnt;
    cur = (r & 1) * MaxCols;
    prv = ((r + 1) & 1) * MaxCols;
    n0 = normal_q.size();
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    if (r >= 1) begin
      if (r - 1 == 0 || c == 0 || c == w - 1) begin
        for (int i = 0; i < 4; i++) push_normal(c, r - 1, i, flat);
      end else begin
        ctr = '{$signed(store_x[prv+c]), $signed(store_y[prv+c]), $signed(store_z[prv+c])};
        lp = '{$signed(store_x[prv+c-1]), $signed(store_y[prv+c-1]),
               $signed(store_z[prv+c-1])};
        rp = '{$signed(store_x[prv+c+1]), $signed(store_y[prv+c+1]),
               $signed(store_z[prv+c+1])};
        dp = '{$signed(store_x[cur+c]), $signed(store_y[cur+c]), $signed(store_z[cur+c])};
        for (int j = 0; j < 3; j++) begin
          up[j] = p[j] - ctr[j];
          dn[j] = dp[j] - ctr[j];
          lf[j] = lp[j] - ctr[j];
          rt[j] = rp[j] - ctr[j];
        end
        cross3(up, lf, x); unit_normal(x, nv); push_normal(c, r - 1, 0, nv);
        cross3(rt, up, x); unit_normal(x, nv); push_normal(c, r - 1, 1, nv);
        cross3(lf, dn, x); unit_normal(x, nv); push_normal(c, r - 1, 2, nv);
        cross3(dn, rt, x); unit_normal(x, nv); push_normal(c, r - 1, 3, nv);
      end
    end
    if (r == len - 1) begin
      for (int i = 0; i < 4; i++) push_normal(c, r, i, flat);
    end
    if (normal_q.size() > n0) normal_q[normal_q.size()-1].last = 1'b1;
    store_x[cur+c] = v.pos_x;
    store_y[cur+c] = v.pos_y;
    store_z[cur+c] = v.pos_z;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= len) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (vertex_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= vertex_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_normals(in_data);
      n_vertices++;
    end
  end

  // monitor
  always @(posedge clk) begin
    gvn_pkg::normal_t e;
    out_ready <= !rst && ($urandom_range(99) >= receiver_idle_pct);
    if (!rst && out_valid && out_ready) begin
      n_normals++;
      if (normal_q.size() == 0) begin
        $error("unexpected normal transaction %p", out_data);
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (out_data.column !== e.column) begin
          $error("column exp %0d got %0d", e.column, out_data.column); errors++;
        end
        if (out_data.row !== e.row) begin
          $error("row exp %0d got %0d", e.row, out_data.row); errors++;
        end
        if (out_data.corner !== e.corner) begin
          $error("corner exp %0d got %0d", e.corner, out_data.corner); errors++;
        end
        if (out_data.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, out_data.normal_x); errors++;
        end
        if (out_data.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, out_data.normal_y); errors++;
        end
        if (out_data.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, out_data.normal_z); errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegAddrWidth) cfg_width = data[6:0];
    else cfg_length = data[12:0];
    col_cnt = 0;
    row_cnt = 0;
  endtask

  task automatic drain();
    while (vertex_q.size() > 0 || in_valid || normal_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord(int spread);
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'(-$urandom_range(spread));
      default: return 24'($urandom_range(2 * spread) - spread);
    endcase
  endfunction

  // one grid of width*length vertices on a noisy height field
  task automatic queue_grid(int w, int len, int noise);
    gvn_pkg::vertex_t v;
    for (int r = 0; r < len; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(19) == 0) begin
          v = {24'($urandom), 24'($urandom), 24'($urandom)};
        end else begin
          v.pos_x = 24'(c * 256 + $urandom_range(noise));
          v.pos_y = rand_coord(4096);
          v.pos_z = 24'(r * 256 + $urandom_range(noise));
        end
        vertex_q.push_back(v);
      end
    end
  endtask

  initial begin
    int widths[5] = '{3, 4, 2, 5, 6};
    int lengths[5] = '{3, 4, 2, 3, 0};
    gvn_pkg::vertex_t v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: 3x3 grids, extreme coordinates, flat plane and zero cross products
    apb_write(RegAddrWidth, 32'd3);
    apb_write(RegAddrLength, 32'd3);
    vertex_q.push_back({24'h800000, 24'h800000, 24'h800000});
    vertex_q.push_back({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    vertex_q.push_back({24'h000000, 24'hFFFFFF, 24'h555555});
    vertex_q.push_back({24'hAAAAAA, 24'h123456, 24'h800000});
    vertex_q.push_back({24'h7FFFFF, 24'h800000, 24'h7FFFFF});
    vertex_q.push_back({24'h000100, 24'h000000, 24'h000000});
    for (int i = 0; i < 3; i++) vertex_q.push_back('0);
    for (int i = 0; i < 9; i++) vertex_q.push_back('0);
    drain();
    // register corner values, including clamped sizes
    apb_write(RegAddrWidth, 32'd0);
    apb_write(RegAddrLength, 32'd1);
    for (int i = 0; i < 4; i++) vertex_q.push_back({24'(i), 24'h7FFFFF, 24'(-i)});
    drain();
    apb_write(RegAddrWidth, 32'd127);
    apb_write(RegAddrLength, 32'h1FFF);
    for (int i = 0; i < 3 * 64; i++) vertex_q.push_back({24'(i), 24'($urandom), 24'(i)});
    drain();
    // random grids across three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = ph == 0 ? 37 : (ph == 1 ? 86 : 0);
      receiver_idle_pct = ph == 0 ? 86 : (ph == 1 ? 37 : 0);
      for (int g = 0; g < 5; g++) begin
        apb_write(RegAddrWidth, 32'(widths[g]));
        apb_write(RegAddrLength, 32'(lengths[g] == 0 ? $urandom_range(6, 2) : lengths[g]));
        queue_grid(widths[g] < 2 ? 2 : widths[g], lengths[g] == 0 ? 3 : lengths[g],
                   g == 2 ? 0 : 511);
        if (g == 3) begin
          for (int i = 0; i < 7; i++) begin
            v = {24'($urandom), 24'($urandom), 24'($urandom)};
            vertex_q.push_back(v);
          end
        end
        drain();
      end
    end
    $display("tb: %0d vertices sent, %0d normals checked over several grid sizes",
             n_vertices, n_normals);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
